[sv/d2cf_pkg.sv]
// Shared types, constants and helpers for the double-to-custom-format converter.
package d2cf_pkg;

  localparam int OUT_WIDTH = 64;

  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 6;

  localparam logic [CFG_IDX_W-1:0] REG_EXP_INT_W  = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_FRAC_W     = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_Q_MODE     = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_KEEP_SUB   = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_SIGNED_FMT = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_FLAG_EN    = 3'd5;

  localparam logic [1:0] STATUS_OK      = 2'd0;
  localparam logic [1:0] STATUS_UNSUP   = 2'd1;
  localparam logic [1:0] STATUS_ILLEGAL = 2'd2;

  localparam logic [10:0] DBL_EXP_ONES = 11'h7FF;
  localparam logic [63:0] DBL_ONE      = 64'h3FF0_0000_0000_0000;

  localparam int FLAG_NAN  = 0;
  localparam int FLAG_INF  = 1;
  localparam int FLAG_ONE  = 2;
  localparam int FLAG_ZERO = 3;

  typedef struct packed {
    logic [5:0] ew;
    logic [5:0] fw;
    logic       q_mode;
    logic       keep_sub;
    logic       signed_fmt;
    logic [3:0] flag_en;
  } cfg_t;

  typedef enum logic [1:0] {
    NUM_ZERO,
    NUM_ONES,
    NUM_SHIFT,
    NUM_QINF
  } num_kind_t;

  typedef enum logic [1:0] {
    EXP_ZERO,
    EXP_ONES,
    EXP_BIAS
  } exp_kind_t;

  typedef struct packed {
    logic      sign;
    logic      is_nan;
    logic      inf_flag;
    logic      is_one;
    logic      is_zero;
    logic      illegal;
    logic      unsup;
    logic      chk_sticky;
    logic      negate;
    num_kind_t num_kind;
    exp_kind_t exp_kind;
  } tag_t;

  typedef struct packed {
    tag_t        tag;
    logic [52:0] src;
    logic [12:0] amt;
    logic [11:0] e;
  } dec_t;

  typedef struct packed {
    tag_t        tag;
    logic [63:0] shifted;
    logic        sticky;
    logic [63:0] expf;
  } shf_t;

  typedef struct packed {
    logic [63:0] num;
    logic [63:0] hi;
    logic [4:0]  tail;
    logic [6:0]  tail_pos;
    logic [1:0]  status;
  } frm_t;

  function automatic logic [63:0] low_mask(input logic [6:0] width);
    low_mask = (width >= 7'd64) ? {64{1'b1}} : ~({64{1'b1}} << width[5:0]);
  endfunction

endpackage

[sv/double_to_custom_float_or_fixed.sv]
// Converts a binary64 pattern into a configured custom float or Q fixed-point word.
// Usage:
//   Input: drive double_bits and pulse start; a beat is taken on any edge with
//   start high and busy low. busy stays low, so a new double can go in every cycle.
//   Output: done is high for one cycle with packed_word and status; the receiver
//   cannot stall, so every result must be captured in that cycle.
//   Path: the decode, shift, field forming and packing registers lie between the
//   accepting edge and done. Throughput: one per cycle.
//   The 64-bit mantissa shifter and the exponent rebias adder set the stage depth.
//   Configuration: cfg_valid/cfg_ready write channel with cfg_index and cfg_data;
//   cfg_ready is always high. Write only while no conversion is in flight.
//   Register map: 0 exponent/integer width, 1 fraction width, 2 Q mode,
//   3 keep subnormals, 4 signed format, 5 flag enables; other indexes are ignored.
//   Reset: rst clears the pipeline valids and restores the default format
//   (8-bit exponent, 23-bit fraction, float, flush subnormals, signed, no flags).
module double_to_custom_float_or_fixed (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            start,
  output logic                            busy,
  input  logic [63:0]                     double_bits,
  output logic                            done,
  output logic [d2cf_pkg::OUT_WIDTH-1:0]  packed_word,
  output logic [1:0]                      status,
  input  logic                            cfg_valid,
  output logic                            cfg_ready,
  input  logic [d2cf_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [d2cf_pkg::CFG_DATA_W-1:0] cfg_data
);

  d2cf_pkg::cfg_t cfg;
  logic           accept;
  logic           dec_valid;
  d2cf_pkg::dec_t dec;
  logic           shf_valid;
  d2cf_pkg::shf_t shf;
  logic           frm_valid;
  d2cf_pkg::frm_t frm;

  assign busy      = 1'b0;
  assign cfg_ready = 1'b1;
  assign accept    = start && !busy;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.ew         <= 6'd8;
      cfg.fw         <= 6'd23;
      cfg.q_mode     <= 1'b0;
      cfg.keep_sub   <= 1'b0;
      cfg.signed_fmt <= 1'b1;
      cfg.flag_en    <= 4'd0;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        d2cf_pkg::REG_EXP_INT_W:  cfg.ew         <= cfg_data[5:0];
        d2cf_pkg::REG_FRAC_W:     cfg.fw         <= cfg_data[5:0];
        d2cf_pkg::REG_Q_MODE:     cfg.q_mode     <= cfg_data[0];
        d2cf_pkg::REG_KEEP_SUB:   cfg.keep_sub   <= cfg_data[0];
        d2cf_pkg::REG_SIGNED_FMT: cfg.signed_fmt <= cfg_data[0];
        d2cf_pkg::REG_FLAG_EN:    cfg.flag_en    <= cfg_data[3:0];
        default: ;
      endcase
    end
  end

  d2cf_decode u_decode (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (accept),
    .double_bits(double_bits),
    .cfg        (cfg),
    .dec_valid  (dec_valid),
    .dec        (dec)
  );

  d2cf_shift u_shift (
    .clk      (clk),
    .rst      (rst),
    .dec_valid(dec_valid),
    .dec      (dec),
    .cfg      (cfg),
    .shf_valid(shf_valid),
    .shf      (shf)
  );

  d2cf_form u_form (
    .clk      (clk),
    .rst      (rst),
    .shf_valid(shf_valid),
    .shf      (shf),
    .cfg      (cfg),
    .frm_valid(frm_valid),
    .frm      (frm)
  );

  d2cf_pack u_pack (
    .clk        (clk),
    .rst        (rst),
    .frm_valid  (frm_valid),
    .frm        (frm),
    .cfg        (cfg),
    .done       (done),
    .packed_word(packed_word),
    .status     (status)
  );

endmodule

[sv/d2cf_decode.sv]
// Stage 1: classify the double and pick shift source, shift amount and field kinds.
module d2cf_decode (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  input  logic [63:0]       double_bits,
  input  d2cf_pkg::cfg_t    cfg,
  output logic              dec_valid,
  output d2cf_pkg::dec_t    dec
);

  d2cf_pkg::dec_t     dec_next;
  logic               sgn;
  logic [10:0]        ebits;
  logic [51:0]        m;
  logic [52:0]        full;
  logic               is_zero, is_sub, is_inf, is_nan;
  logic signed [13:0] e_w, fw_s, bias_w;
  logic signed [13:0] amt_align, amt_q, amt_sub;
  logic               ew_narrow, over, under;
  logic [10:0]        bias_s;
  logic [6:0]         nw;

  always_comb begin
    sgn     = double_bits[63];
    ebits   = double_bits[62:52];
    m       = double_bits[51:0];
    full    = {1'b1, m};
    is_zero = (ebits == 11'd0) && (m == 52'd0);
    is_sub  = (ebits == 11'd0) && (m != 52'd0);
    is_inf  = (ebits == d2cf_pkg::DBL_EXP_ONES) && (m == 52'd0);
    is_nan  = (ebits == d2cf_pkg::DBL_EXP_ONES) && (m != 52'd0);
    e_w     = $signed({3'b000, ebits}) - 14'sd1023;
    fw_s    = $signed({8'd0, cfg.fw});
    nw      = {1'b0, cfg.ew} + {1'b0, cfg.fw};

    // exponent widths of 12 and up never overflow or underflow a double
    ew_narrow = cfg.ew < 6'd12;
    bias_s    = (cfg.ew == 6'd0 || !ew_narrow) ? 11'd0 :
                11'((12'd1 << (cfg.ew[3:0] - 4'd1)) - 12'd1);
    bias_w    = $signed({3'b000, bias_s});
    over      = ew_narrow && (e_w > bias_w);
    under     = ew_narrow && (e_w < (14'sd1 - bias_w));

    amt_align = 14'sd52 - fw_s;
    amt_q     = 14'sd52 - fw_s - e_w;
    amt_sub   = 14'sd52 - fw_s + 14'sd1 - bias_w - e_w;

    dec_next                = '0;
    dec_next.tag.sign       = sgn;
    dec_next.tag.is_nan     = is_nan;
    dec_next.tag.inf_flag   = is_inf;
    dec_next.tag.is_one     = double_bits == d2cf_pkg::DBL_ONE;
    dec_next.tag.is_zero    = is_zero;
    dec_next.tag.num_kind   = d2cf_pkg::NUM_ZERO;
    dec_next.tag.exp_kind   = d2cf_pkg::EXP_ZERO;
    dec_next.src            = {1'b0, m};
    dec_next.amt            = amt_align[12:0];
    dec_next.e              = e_w[11:0];

    if (cfg.q_mode) begin
      if (is_nan || is_zero || (is_sub && !cfg.keep_sub)) begin
        dec_next.tag.num_kind = d2cf_pkg::NUM_ZERO;
      end else if (is_inf) begin
        dec_next.tag.num_kind = d2cf_pkg::NUM_QINF;
        dec_next.tag.illegal  = !cfg.flag_en[d2cf_pkg::FLAG_INF];
      end else if (nw >= 7'd64) begin
        dec_next.tag.illegal  = 1'b1;
      end else if (is_sub) begin
        dec_next.tag.unsup    = 1'b1;
      end else begin
        dec_next.tag.num_kind = d2cf_pkg::NUM_SHIFT;
        dec_next.tag.negate   = cfg.signed_fmt && sgn;
        dec_next.src          = full;
        dec_next.amt          = amt_q[12:0];
      end
    end else begin
      if (is_zero) begin
        dec_next.tag.num_kind = d2cf_pkg::NUM_ZERO;
      end else if (is_sub) begin
        if (cfg.keep_sub) begin
          dec_next.tag.num_kind = d2cf_pkg::NUM_SHIFT;
        end
      end else if (is_inf) begin
        dec_next.tag.exp_kind = d2cf_pkg::EXP_ONES;
      end else if (is_nan) begin
        dec_next.tag.exp_kind = d2cf_pkg::EXP_ONES;
        dec_next.tag.num_kind = d2cf_pkg::NUM_ONES;
      end else if (over) begin
        dec_next.tag.inf_flag = 1'b1;
        dec_next.tag.exp_kind = d2cf_pkg::EXP_ONES;
      end else if (under) begin
        if (cfg.keep_sub) begin
          dec_next.tag.num_kind   = d2cf_pkg::NUM_SHIFT;
          dec_next.tag.chk_sticky = 1'b1;
          dec_next.src            = full;
          dec_next.amt            = amt_sub[12:0];
        end
      end else begin
        dec_next.tag.num_kind = d2cf_pkg::NUM_SHIFT;
        dec_next.tag.exp_kind = d2cf_pkg::EXP_BIAS;
      end
      dec_next.tag.illegal = !cfg.signed_fmt && sgn;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      dec_valid <= 1'b0;
    end else begin
      dec_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid) begin
      dec <= dec_next;
    end
  end

endmodule

[sv/d2cf_shift.sv]
// Stage 2: barrel shift of the mantissa with lost-bit detect, and exponent rebias.
module d2cf_shift (
  input  logic              clk,
  input  logic              rst,
  input  logic              dec_valid,
  input  d2cf_pkg::dec_t    dec,
  input  d2cf_pkg::cfg_t    cfg,
  output logic              shf_valid,
  output d2cf_pkg::shf_t    shf
);

  d2cf_pkg::shf_t     shf_next;
  logic signed [12:0] amt_s;
  logic [12:0]        neg_amt;
  logic [63:0]        src64;
  logic [63:0]        bias64;
  logic [63:0]        e64;

  always_comb begin
    amt_s   = $signed(dec.amt);
    neg_amt = 13'd0 - dec.amt;
    src64   = {11'd0, dec.src};
    bias64  = (cfg.ew == 6'd0) ? 64'd0 : ((64'd1 << (cfg.ew - 6'd1)) - 64'd1);
    e64     = {{52{dec.e[11]}}, dec.e};

    shf_next      = '0;
    shf_next.tag  = dec.tag;
    shf_next.expf = bias64 + e64;
    if (amt_s >= 13'sd64) begin
      // everything shifts out
      shf_next.sticky = src64 != 64'd0;
    end else if (amt_s <= -13'sd64) begin
      shf_next.shifted = 64'd0;
    end else if (amt_s < 13'sd0) begin
      shf_next.shifted = src64 << neg_amt[5:0];
    end else begin
      shf_next.shifted = src64 >> dec.amt[5:0];
      shf_next.sticky  = (src64 & ~({64{1'b1}} << dec.amt[5:0])) != 64'd0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      shf_valid <= 1'b0;
    end else begin
      shf_valid <= dec_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (dec_valid) begin
      shf <= shf_next;
    end
  end

endmodule

[sv/d2cf_form.sv]
// Stage 3: form the number and exponent fields, negate, collect tail bits and status.
module d2cf_form (
  input  logic              clk,
  input  logic              rst,
  input  logic              shf_valid,
  input  d2cf_pkg::shf_t    shf,
  input  d2cf_pkg::cfg_t    cfg,
  output logic              frm_valid,
  output d2cf_pkg::frm_t    frm
);

  d2cf_pkg::frm_t frm_next;
  logic [6:0]     nw;
  logic [6:0]     nw_m1;
  logic           top_ok;
  logic [63:0]    top_bit;
  logic [63:0]    nw_mask;
  logic [63:0]    num_q;
  logic [63:0]    mant;
  logic [63:0]    expf;
  logic [4:0]     tail;
  logic [2:0]     k;
  logic           unsup;

  always_comb begin
    nw      = {1'b0, cfg.ew} + {1'b0, cfg.fw};
    nw_m1   = nw - 7'd1;
    nw_mask = d2cf_pkg::low_mask(nw);
    top_ok  = cfg.signed_fmt && (nw != 7'd0) && (nw <= 7'd64);
    top_bit = top_ok ? (64'd1 << nw_m1[5:0]) : 64'd0;

    num_q = shf.shifted & nw_mask;
    if (shf.tag.negate) begin
      num_q = (64'd0 - num_q) & nw_mask;
    end

    case (shf.tag.num_kind)
      d2cf_pkg::NUM_ONES:  mant = {64{1'b1}};
      d2cf_pkg::NUM_SHIFT: mant = shf.shifted;
      default:             mant = 64'd0;
    endcase
    mant = mant & d2cf_pkg::low_mask({1'b0, cfg.fw});

    case (shf.tag.exp_kind)
      d2cf_pkg::EXP_ONES: expf = {64{1'b1}};
      d2cf_pkg::EXP_BIAS: expf = shf.expf;
      default:            expf = 64'd0;
    endcase
    expf = expf & d2cf_pkg::low_mask({1'b0, cfg.ew});

    // pack sign and enabled flags densely, in output order
    tail = 5'd0;
    k    = 3'd0;
    if (!cfg.q_mode && cfg.signed_fmt) begin
      tail[k] = shf.tag.sign;
      k       = k + 3'd1;
    end
    if (cfg.flag_en[d2cf_pkg::FLAG_NAN]) begin
      tail[k] = shf.tag.is_nan;
      k       = k + 3'd1;
    end
    if (cfg.flag_en[d2cf_pkg::FLAG_INF]) begin
      tail[k] = shf.tag.inf_flag;
      k       = k + 3'd1;
    end
    if (cfg.flag_en[d2cf_pkg::FLAG_ONE]) begin
      tail[k] = shf.tag.is_one;
      k       = k + 3'd1;
    end
    if (cfg.flag_en[d2cf_pkg::FLAG_ZERO]) begin
      tail[k] = shf.tag.is_zero;
    end

    unsup = shf.tag.unsup || (shf.tag.chk_sticky && shf.sticky);

    frm_next          = '0;
    frm_next.tail     = tail;
    frm_next.tail_pos = nw;
    if (cfg.q_mode) begin
      case (shf.tag.num_kind)
        d2cf_pkg::NUM_SHIFT: frm_next.num = num_q;
        d2cf_pkg::NUM_QINF:  frm_next.num = shf.tag.sign ? top_bit : (nw_mask & ~top_bit);
        default:             frm_next.num = 64'd0;
      endcase
    end else begin
      frm_next.num = mant;
      frm_next.hi  = expf;
    end

    if (shf.tag.illegal) begin
      frm_next.status = d2cf_pkg::STATUS_ILLEGAL;
    end else if (unsup) begin
      frm_next.status = d2cf_pkg::STATUS_UNSUP;
    end else begin
      frm_next.status = d2cf_pkg::STATUS_OK;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      frm_valid <= 1'b0;
    end else begin
      frm_valid <= shf_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (shf_valid) begin
      frm <= frm_next;
    end
  end

endmodule

[sv/d2cf_pack.sv]
// Stage 4: place exponent and tail bits into the output word and register the result.
module d2cf_pack (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           frm_valid,
  input  d2cf_pkg::frm_t                 frm,
  input  d2cf_pkg::cfg_t                 cfg,
  output logic                           done,
  output logic [d2cf_pkg::OUT_WIDTH-1:0] packed_word,
  output logic [1:0]                     status
);

  logic [63:0] word_next;
  logic [63:0] tail_word;

  always_comb begin
    // tail bits that would land past the top are dropped
    tail_word = (frm.tail_pos < 7'd64) ? ({59'd0, frm.tail} << frm.tail_pos[5:0]) : 64'd0;
    word_next = frm.num | (frm.hi << cfg.fw) | tail_word;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= frm_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (frm_valid) begin
      packed_word <= word_next[d2cf_pkg::OUT_WIDTH-1:0];
      status      <= frm.status;
    end
  end

endmodule

[tb/testbench.sv]
// Self-checking testbench for the double to custom float / Q fixed-point converter.
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int IDLE_LIMIT   = 2000;
  localparam int DRAIN_CYCLES = 8;
  localparam int PHASE_ITEMS  = 48;

  localparam logic [d2cf_pkg::CFG_IDX_W-1:0] REG_UNUSED = 3'd6;

  typedef struct packed {
    logic [63:0] word;
    logic [1:0]  status;
  } conv_t;

  logic                            clk         = 1'b0;
  logic                            rst         = 1'b1;
  logic                            start       = 1'b0;
  logic                            busy;
  logic [63:0]                     double_bits = '0;
  logic                            done;
  logic [d2cf_pkg::OUT_WIDTH-1:0]  packed_word;
  logic [1:0]                      status;
  logic                            cfg_valid   = 1'b0;
  logic                            cfg_ready;
  logic [d2cf_pkg::CFG_IDX_W-1:0]  cfg_index   = '0;
  logic [d2cf_pkg::CFG_DATA_W-1:0] cfg_data    = '0;

  // Format mirror, starts at the reset defaults.
  d2cf_pkg::cfg_t fmt = '{6'd8, 6'd23, 1'b0, 1'b0, 1'b1, 4'd0};
  conv_t pending_results[$];
  int    error_count = 0;
  int    idle_cycles = 0;
  int    burst_left  = 0;

  always #5 clk = ~clk;

  double_to_custom_float_or_fixed u_top (
    .clk         (clk),
    .rst         (rst),
    .start       (start),
    .busy        (busy),
    .double_bits (double_bits),
    .done        (done),
    .packed_word (packed_word),
    .status      (status),
    .cfg_valid   (cfg_valid),
    .cfg_ready   (cfg_ready),
    .cfg_index   (cfg_index),
    .cfg_data    (cfg_data)
  );

  function automatic logic [63:0] ones_below(int width);
    return (width >= 64) ? '1 : ((64'd1 << width) - 64'd1);
  endfunction

  function automatic logic [63:0] put_bits(logic [63:0] word, int lsb, logic [63:0] val,
                                           int width);
    if (lsb >= 64) return word;
    return word | ((val & ones_below(width)) << lsb);
  endfunction

  function automatic logic [63:0] align_frac(logic [63:0] val, int fw);
    return (fw <= 52) ? (val >> (52 - fw)) : (val << (fw - 52));
  endfunction

  function automatic conv_t convert_double(logic [63:0] x);
    logic        sgn;
    longint      eraw, e, bias, sh;
    logic [63:0] frac, full, w, num, mant, expf;
    bit          zero_in, sub_in, inf_in, nan_in, inf_out, illegal, unsup;
    int          ew, fw, nw, pos;
    conv_t       r;
    sgn     = x[63];
    eraw    = longint'(x[62:52]);
    frac    = {12'd0, x[51:0]};
    full    = frac | (64'd1 << 52);
    zero_in = (eraw == 0) && (frac == 0);
    sub_in  = (eraw == 0) && (frac != 0);
    inf_in  = (x[62:52] == d2cf_pkg::DBL_EXP_ONES) && (frac == 0);
    nan_in  = (x[62:52] == d2cf_pkg::DBL_EXP_ONES) && (frac != 0);
    e       = eraw - 1023;
    ew      = int'(fmt.ew);
    fw      = int'(fmt.fw);
    inf_out = inf_in;
    illegal = 1'b0;
    unsup   = 1'b0;
    w       = '0;
    mant    = '0;
    expf    = '0;
    if (fmt.q_mode) begin
      nw = ew + fw;
      if (nan_in || zero_in || (sub_in && !fmt.keep_sub)) begin
        w = '0;
      end else if (inf_in) begin
        // saturate: signed gives top bit alone for minus, all but top bit for plus; unsigned gives 0 or all ones
        if (sgn) begin
          if (fmt.signed_fmt && nw >= 1 && nw - 1 < 64) w = 64'd1 << (nw - 1);
        end else begin
          w = ones_below(nw);
          if (fmt.signed_fmt && nw >= 1 && nw - 1 < 64) w &= ~(64'd1 << (nw - 1));
        end
        if (!fmt.flag_en[d2cf_pkg::FLAG_INF]) illegal = 1'b1;
      end else if (nw >= 64) begin
        illegal = 1'b1;
      end else if (sub_in) begin
        unsup = 1'b1;
      end else begin
        sh = 52 - fw - e;
        if (sh <= -64 || sh >= 64) num = '0;
        else if (sh < 0) num = full << (-sh);
        else num = full >> sh;
        num &= ones_below(nw);
        if (fmt.signed_fmt && sgn) num = (-num) & ones_below(nw);
        w = num;
      end
      pos = nw;
    end else begin
      bias = 0;
      if (ew > 0) bias = (64'sd1 << (ew - 1)) - 1;
      if (sub_in) begin
        if (fmt.keep_sub) mant = align_frac(frac, fw);
      end else if (inf_in) begin
        expf = ones_below(ew);
      end else if (nan_in) begin
        expf = ones_below(ew);
        mant = ones_below(fw);
      end else if (!zero_in) begin
        if (e > bias) begin
          inf_out = 1'b1;
          expf    = ones_below(ew);
        end else if (e < 1 - bias) begin
          if (fmt.keep_sub) begin
            sh = 52 - fw + (1 - bias - e);
            if (sh <= 0) begin
              mant = full << (-sh);
            end else if (sh >= 64) begin
              mant  = '0;
              unsup = 1'b1;
            end else begin
              mant = full >> sh;
              // flag any bit lost off the bottom
              if ((full & ones_below(int'(sh))) != 0) unsup = 1'b1;
            end
          end
        end else begin
          mant = align_frac(frac, fw);
          expf = e + bias;
        end
      end
      w   = put_bits(w, 0, mant, fw);
      w   = put_bits(w, fw, expf, ew);
      pos = fw + ew;
      if (fmt.signed_fmt) begin
        w = put_bits(w, pos, 64'(sgn), 1);
        pos++;
      end else if (sgn) begin
        illegal = 1'b1;
      end
    end
    if (fmt.flag_en[d2cf_pkg::FLAG_NAN]) begin
      w = put_bits(w, pos, 64'(nan_in), 1);
      pos++;
    end
    if (fmt.flag_en[d2cf_pkg::FLAG_INF]) begin
      w = put_bits(w, pos, 64'(inf_out), 1);
      pos++;
    end
    if (fmt.flag_en[d2cf_pkg::FLAG_ONE]) begin
      w = put_bits(w, pos, 64'(x == d2cf_pkg::DBL_ONE), 1);
      pos++;
    end
    if (fmt.flag_en[d2cf_pkg::FLAG_ZERO]) begin
      w = put_bits(w, pos, 64'(x[62:0] == 63'd0), 1);
      pos++;
    end
    r.word   = w;
    r.status = illegal ? d2cf_pkg::STATUS_ILLEGAL :
               (unsup ? d2cf_pkg::STATUS_UNSUP : d2cf_pkg::STATUS_OK);
    return r;
  endfunction

  // Mostly values near the configured range, plus specials and raw bit patterns.
  function automatic logic [63:0] random_double();
    logic [63:0] x;
    longint      lo, hi, bias, e;
    int          ew, fw;
    x  = {$urandom, $urandom};
    ew = int'(fmt.ew);
    fw = int'(fmt.fw);
    if (fmt.q_mode) begin
      lo = -fw - 3;
      hi = ew + 2;
    end else begin
      bias = 0;
      if (ew > 0) bias = (64'sd1 << (ew - 1)) - 1;
      lo = 1 - bias - fw - 4;
      hi = bias + 2;
    end
    if (lo < -1022) lo = -1022;
    if (hi > 1023) hi = 1023;
    case ($urandom_range(0, 15))
      0: x[62:0] = '0;
      1: x[62:0] = {d2cf_pkg::DBL_EXP_ONES, 52'd0};
      2: x[62:52] = d2cf_pkg::DBL_EXP_ONES;
      3: x[62:52] = '0;
      4: x = d2cf_pkg::DBL_ONE;
      5, 6: x = x;
      default: begin
        e = lo + longint'($urandom_range(0, 32'(hi - lo)));
        x[62:52] = 11'(e + 1023);
        // short mantissas give exact conversions
        if ($urandom_range(0, 3) == 0) x[40:0] = '0;
      end
    endcase
    return x;
  endfunction

  task automatic write_reg(logic [d2cf_pkg::CFG_IDX_W-1:0] idx,
                           logic [d2cf_pkg::CFG_DATA_W-1:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    case (idx)
      d2cf_pkg::REG_EXP_INT_W:  fmt.ew         = data;
      d2cf_pkg::REG_FRAC_W:     fmt.fw         = data;
      d2cf_pkg::REG_Q_MODE:     fmt.q_mode     = data[0];
      d2cf_pkg::REG_KEEP_SUB:   fmt.keep_sub   = data[0];
      d2cf_pkg::REG_SIGNED_FMT: fmt.signed_fmt = data[0];
      d2cf_pkg::REG_FLAG_EN:    fmt.flag_en    = data[3:0];
      default: ;
    endcase
  endtask

  task automatic wait_drained();
    start      <= 1'b0;
    burst_left  = 0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic set_format(int ew, int fw, bit q, bit keep, bit sgn, logic [3:0] flags);
    wait_drained();
    write_reg(d2cf_pkg::REG_EXP_INT_W, ew[5:0]);
    write_reg(d2cf_pkg::REG_FRAC_W, fw[5:0]);
    // upper data bits of narrow registers are noise
    write_reg(d2cf_pkg::REG_Q_MODE, {5'($urandom), q});
    write_reg(d2cf_pkg::REG_KEEP_SUB, {5'($urandom), keep});
    write_reg(d2cf_pkg::REG_SIGNED_FMT, {5'($urandom), sgn});
    write_reg(d2cf_pkg::REG_FLAG_EN, {2'($urandom), flags});
    write_reg(REG_UNUSED, 6'($urandom));
    cfg_valid <= 1'b0;
  endtask

  task automatic send_double(logic [63:0] x);
    int gap;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
      if (gap > 0) begin
        start <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      burst_left = $urandom_range(1, 24);
    end
    burst_left--;
    start       <= 1'b1;
    double_bits <= x;
    @(posedge clk);
    while (busy) @(posedge clk);
    pending_results = {pending_results, convert_double(x)};
  endtask

  task automatic run_phase(bit q, int ew, int fw);
    set_format(ew, fw, q, 1'($urandom), 1'($urandom), 4'($urandom));
    repeat (PHASE_ITEMS) send_double(random_double());
  endtask

  task automatic test_reset_format();
    send_double(d2cf_pkg::DBL_ONE);
    send_double(64'hC000_0000_0000_0000);
    send_double(64'h000F_FFFF_FFFF_FFFF);
    send_double(64'hFFFF_FFFF_FFFF_FFFF);
  endtask

  task automatic test_float_corners();
    set_format(8, 23, 1'b0, 1'b1, 1'b1, 4'hF);
    send_double(64'h0000_0000_0000_0000);
    send_double(64'h8000_0000_0000_0000);
    send_double(d2cf_pkg::DBL_ONE);
    send_double(64'h7FF0_0000_0000_0000);
    send_double(64'hFFF0_0000_0000_0000);
    send_double(64'h7FF0_0000_0000_0001);
    send_double(64'h0000_0000_0000_0001);
    send_double(64'h7FEF_FFFF_FFFF_FFFF);
    send_double(64'h3800_0000_0000_0000);
    send_double(64'h3800_0000_0000_0001);
  endtask

  task automatic test_float_widths();
    set_format(0, 63, 1'b0, 1'b0, 1'b0, 4'h0);
    send_double(64'hBFF8_0000_0000_0000);
    send_double(d2cf_pkg::DBL_ONE);
    set_format(11, 60, 1'b0, 1'b1, 1'b1, 4'hF);
    send_double(64'h0000_0000_0000_0001);
    set_format(63, 52, 1'b0, 1'b0, 1'b1, 4'hF);
    send_double(d2cf_pkg::DBL_ONE);
  endtask

  task automatic test_q_corners();
    set_format(4, 8, 1'b1, 1'b0, 1'b1, 4'h2);
    send_double(64'h7FF0_0000_0000_0000);
    send_double(64'hFFF0_0000_0000_0000);
    send_double(64'hC004_0000_0000_0000);
    send_double(64'h4059_0000_0000_0000);
    send_double(64'h0000_0000_0000_0001);
    set_format(4, 8, 1'b1, 1'b1, 1'b0, 4'h0);
    send_double(64'h7FF0_0000_0000_0000);
    send_double(64'hFFF0_0000_0000_0000);
    send_double(64'h8000_0000_0000_0001);
    send_double(64'hC008_0000_0000_0000);
    set_format(40, 24, 1'b1, 1'b0, 1'b1, 4'hF);
    send_double(d2cf_pkg::DBL_ONE);
    send_double(64'h7FF8_0000_0000_0001);
  endtask

  task automatic test_random_float();
    run_phase(1'b0, 0, 0);
    run_phase(1'b0, 63, 63);
    run_phase(1'b0, 11, 52);
    repeat (4) begin
      run_phase(1'b0,
                ($urandom_range(0, 3) == 0) ? $urandom_range(0, 63) : $urandom_range(1, 11),
                ($urandom_range(0, 3) == 0) ? $urandom_range(0, 63) : $urandom_range(0, 52));
    end
  endtask

  task automatic test_random_q();
    run_phase(1'b1, 0, 0);
    run_phase(1'b1, 63, 0);
    run_phase(1'b1, 0, 63);
    run_phase(1'b1, 32, 31);
    repeat (2) run_phase(1'b1, $urandom_range(0, 24), $urandom_range(0, 38));
  endtask

  always @(posedge clk) begin : check_results
    conv_t want;
    if (!rst && done) begin
      if (pending_results.size() == 0) begin
        $error("unexpected beat: packed_word=%h status=%0d", packed_word, status);
        error_count++;
      end else begin
        want = pending_results.pop_front();
        if (packed_word !== want.word) begin
          $error("packed_word: expected %h, actual %h", want.word, packed_word);
          error_count++;
        end
        if (status !== want.status) begin
          $error("status: expected %0d, actual %0d", want.status, status);
          error_count++;
        end
      end
    end
  end

  always @(posedge clk) begin
    if (rst || (start && !busy) || done || (cfg_valid && cfg_ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= IDLE_LIMIT) begin
      $display("Testbench completed WITH ERRORS");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin
    repeat (5) @(posedge clk);
    rst <= 1'b0;
    test_reset_format();
    test_float_corners();
    test_float_widths();
    test_q_corners();
    test_random_float();
    test_random_q();
    wait_drained();
    if (error_count == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
